>>> rtl/tdma_pkg.sv
// Package for the TDMA slot task scheduler: operation codes, decisions,
// sequencer states and shared constants. No dependencies.
`default_nettype none
package tdma_pkg;
  localparam int MAX_SLOTS_DEF    = 4;
  localparam int QUEUE_DEPTH_DEF  = 8;
  localparam int TASK_ID_BITS_DEF = 8;
  localparam int SLOT_REGS        = 4;
  localparam int LEN_W            = 16;
  localparam int CYC_W            = 18;
  localparam int TIME_W           = 48;
  localparam logic [15:0] LEN_RESET = 16'd10;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_DECIDE = 2'd2,
    FN_SLICE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DEC_NO_CHANGE   = 2'd0,
    DEC_RESIGNED    = 2'd1,
    DEC_PREEMPT     = 2'd2,
    DEC_ONLY_ASSIGN = 2'd3
  } dec_t;

  typedef enum logic [2:0] {
    CFG_ACTIVE = 3'd0,
    CFG_LEN0   = 3'd1,
    CFG_LEN1   = 3'd2,
    CFG_LEN2   = 3'd3,
    CFG_LEN3   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    LS_IDLE,
    LS_SUM,
    LS_DIV,
    LS_FIND,
    LS_DONE
  } loc_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_LOCATE,
    ST_HEAD,
    ST_OUT
  } top_state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } loc_ctl_t;
endpackage
`default_nettype wire

>>> rtl/tdma_slot_task_scheduler.sv
// Top level of the TDMA slot task scheduler: configuration registers, the
// per-slot task queues in one memory, and the sequencer. Uses tdma_pkg and
// tdma_locate.
`default_nettype none
// One item is taken at a time; the input stalls until its result transfer.
// An add writes the task at the tail of its slot's queue if there is room
// and then offers its result. A remove reads the slot's queue one entry a
// cycle through the memory's read port and, once it finds the task, moves
// the tail down one entry a cycle. A decide or a slice query with work runs
// the slot locator, which sums the active slot lengths, reduces the time
// modulo the cycle length bit by bit over all 48 bits of the time, and walks
// the slots to find the current one. No clearing pass after reset.
module tdma_slot_task_scheduler
  import tdma_pkg::*;
#(
  parameter int MAX_SLOTS    = MAX_SLOTS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_task_id,
  input  wire logic [1:0]  in_task_slot,
  input  wire logic [47:0] in_now_time,
  input  wire logic        in_running_valid,
  input  wire logic [7:0]  in_running_task,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_ok,
  output logic [1:0]       out_decision,
  output logic [7:0]       out_resign_task,
  output logic [7:0]       out_assign_task,
  output logic [17:0]      out_remaining_slice,
  output logic [1:0]       out_current_slot
);
  localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int TW  = $clog2(MAX_SLOTS * QUEUE_DEPTH + 1);
  localparam int IDW = (TASK_ID_BITS < 8) ? TASK_ID_BITS : 8;
  localparam int MD  = MAX_SLOTS * QUEUE_DEPTH;
  localparam int AW  = $clog2(MD);

  top_state_t state_r, state_nxt;
  logic [2:0]                   act_r;
  logic [SLOT_REGS-1:0][LEN_W-1:0] len_r;
  logic [MAX_SLOTS-1:0][FW-1:0] fill_r, fill_nxt;
  logic [TW-1:0]                total_r, total_nxt;
  logic [TASK_ID_BITS-1:0]      mem [MD];
  logic [TASK_ID_BITS-1:0]      rd_r;

  func_t        func_r, func_nxt;
  logic [IDW-1:0] tid_r, tid_nxt, rtask_r, rtask_nxt;
  logic [1:0]   tslot_r, tslot_nxt;
  logic         rvalid_r, rvalid_nxt;
  logic [47:0]  now_r, now_nxt;
  logic [FW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] qs_r, qs_nxt;
  logic         ok_r, ok_nxt;
  logic [1:0]   dec_r, dec_nxt;
  logic [7:0]   res_r, res_nxt, asg_r, asg_nxt;
  logic [17:0]  left_r, left_nxt;
  logic [1:0]   cur_r, cur_nxt;

  logic          we;
  logic [AW-1:0] wa, ra;
  logic [TASK_ID_BITS-1:0] wd;
  logic          loc_start;
  loc_ctl_t      loc_ctl;
  logic [1:0]    loc_slot;
  logic [CYC_W-1:0] loc_left;
  logic [FW-1:0] fq;
  logic          slot_ok;

  tdma_locate #(.MAX_SLOTS(MAX_SLOTS)) u_loc (
    .clk, .rst_n, .start(loc_start), .active_slots(act_r), .slot_len(len_r),
    .now_time(now_r), .ctl(loc_ctl), .slot(loc_slot), .left(loc_left)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 3'd1;
      for (int i = 0; i < SLOT_REGS; i++) len_r[i] <= LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE: act_r <= cfg_data[2:0];
        CFG_LEN0:   len_r[0] <= cfg_data;
        CFG_LEN1:   len_r[1] <= cfg_data;
        CFG_LEN2:   len_r[2] <= cfg_data;
        CFG_LEN3:   len_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
    end
    func_r <= func_nxt; tid_r <= tid_nxt; tslot_r <= tslot_nxt;
    rvalid_r <= rvalid_nxt; rtask_r <= rtask_nxt; now_r <= now_nxt;
    idx_r <= idx_nxt; qs_r <= qs_nxt; ok_r <= ok_nxt; dec_r <= dec_nxt;
    res_r <= res_nxt; asg_r <= asg_nxt; left_r <= left_nxt; cur_r <= cur_nxt;
  end

  function automatic logic [AW-1:0] addr(input logic [SW-1:0] s,
                                         input logic [FW-1:0] i);
    return AW'(s * QUEUE_DEPTH + i);
  endfunction

  assign slot_ok = (32'(tslot_r) < MAX_SLOTS);
  assign fq      = fill_r[qs_r];

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r; total_nxt = total_r;
    func_nxt = func_r; tid_nxt = tid_r; tslot_nxt = tslot_r;
    rvalid_nxt = rvalid_r; rtask_nxt = rtask_r; now_nxt = now_r;
    idx_nxt = idx_r; qs_nxt = qs_r; ok_nxt = ok_r; dec_nxt = dec_r;
    res_nxt = res_r; asg_nxt = asg_r; left_nxt = left_r; cur_nxt = cur_r;
    we = 1'b0; wa = addr(qs_r, fq); wd = TASK_ID_BITS'(tid_r);
    ra = addr(qs_r, idx_r);
    loc_start = 1'b0;
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt   = func_t'(in_func);
          tid_nxt    = in_task_id[IDW-1:0];
          tslot_nxt  = in_task_slot;
          rvalid_nxt = in_running_valid;
          rtask_nxt  = in_running_task[IDW-1:0];
          now_nxt    = in_now_time;
          qs_nxt     = SW'(in_task_slot);
          idx_nxt    = '0;
          ok_nxt = 1'b0; dec_nxt = DEC_NO_CHANGE; res_nxt = '0; asg_nxt = '0;
          left_nxt = '0; cur_nxt = '0;
          priority case (func_t'(in_func))
            FN_ADD, FN_REMOVE: state_nxt = ST_SCAN;
            default: state_nxt = ST_LOCATE;
          endcase
        end
      end
      ST_SCAN: begin
        if (!slot_ok) begin
          state_nxt = ST_OUT;
        end else if (func_r == FN_ADD) begin
          if (32'(fq) < QUEUE_DEPTH) begin
            we = 1'b1;
            fill_nxt[qs_r] = fq + FW'(1);
            total_nxt = total_r + TW'(1);
            ok_nxt = 1'b1;
          end
          state_nxt = ST_OUT;
        end else begin
          // rd_r holds the entry addressed in the previous cycle.
          ra = addr(qs_r, idx_r);
          idx_nxt = idx_r + FW'(1);
          if (idx_r != '0 && rd_r == TASK_ID_BITS'(tid_r)) begin
            idx_nxt = idx_r - FW'(1);
            ra = addr(qs_r, idx_r);
            ok_nxt = 1'b1;
            state_nxt = ST_SHIFT;
          end else if (idx_r == fq) begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_SHIFT: begin
        // Entry idx+1 is in rd_r; write it down to idx.
        ra = addr(qs_r, idx_r + FW'(2));
        if (idx_r + FW'(1) >= fq) begin
          fill_nxt[qs_r] = fq - FW'(1);
          if (total_r != '0) total_nxt = total_r - TW'(1);
          state_nxt = ST_OUT;
        end else begin
          we = 1'b1;
          wa = addr(qs_r, idx_r);
          wd = rd_r;
          idx_nxt = idx_r + FW'(1);
        end
      end
      ST_LOCATE: begin
        if (func_r == FN_SLICE && total_r == '0 && !rvalid_r) begin
          state_nxt = ST_OUT;
        end else if (!loc_ctl.busy) begin
          loc_start = 1'b1;
        end else if (loc_ctl.done) begin
          left_nxt = loc_left;
          cur_nxt  = loc_slot;
          qs_nxt   = SW'(loc_slot);
          if (func_r == FN_SLICE) begin
            ok_nxt = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_HEAD;
          end
        end
        ra = addr(SW'(loc_slot), '0);
      end
      ST_HEAD: begin
        if (rvalid_r) begin
          if (fq != '0 && rd_r == TASK_ID_BITS'(rtask_r)) begin
            dec_nxt = DEC_NO_CHANGE;
          end else begin
            res_nxt = 8'(rtask_r);
            dec_nxt = DEC_RESIGNED;
            if (fq != '0) begin
              asg_nxt = 8'(rd_r);
              dec_nxt = DEC_PREEMPT;
            end
          end
        end else if (fq != '0) begin
          asg_nxt = 8'(rd_r);
          dec_nxt = DEC_ONLY_ASSIGN;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_ok              = ok_r;
  assign out_decision        = dec_r;
  assign out_resign_task     = res_r;
  assign out_assign_task     = asg_r;
  assign out_remaining_slice = left_r;
  assign out_current_slot    = cur_r;
endmodule
`default_nettype wire

>>> rtl/tdma_locate.sv
// Slot locator: sums the slot lengths, reduces the time modulo the cycle one
// bit a cycle with a subtractor, then walks the slots with the shared adder. Uses tdma_pkg.
`default_nettype none
module tdma_locate
  import tdma_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [2:0]                    active_slots,
  input  wire logic [SLOT_REGS-1:0][LEN_W-1:0] slot_len,
  input  wire logic [TIME_W-1:0]             now_time,
  output loc_ctl_t                           ctl,
  output logic [1:0]                         slot,
  output logic [CYC_W-1:0]                   left
);
  localparam int LIM = (MAX_SLOTS < SLOT_REGS) ? MAX_SLOTS : SLOT_REGS;

  loc_state_t state_r, state_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [5:0]        bit_r, bit_nxt;
  logic [CYC_W-1:0]  cyc_r, cyc_nxt;
  logic [CYC_W-1:0]  rem_r, rem_nxt;
  logic [CYC_W-1:0]  end_r, end_nxt;
  logic [TIME_W-1:0] t_r, t_nxt;
  logic [2:0]        n_eff;
  logic [CYC_W-1:0]  len_k;
  logic [CYC_W:0]    trial;
  logic [CYC_W-1:0]  add_sum;

  always_comb begin
    n_eff = active_slots;
    if (n_eff == 3'd0) n_eff = 3'd1;
    if (n_eff > 3'(LIM)) n_eff = 3'(LIM);
    len_k = (slot_len[k_r[1:0]] == '0) ? CYC_W'(1) : CYC_W'(slot_len[k_r[1:0]]);
  end

  // The single shared adder; the subtractor works on the modulo.
  assign add_sum = (state_r == LS_SUM ? cyc_r : end_r) + len_k;
  assign trial   = {rem_r, t_r[TIME_W-1]} - {1'b0, cyc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    k_r   <= k_nxt;
    bit_r <= bit_nxt;
    cyc_r <= cyc_nxt;
    rem_r <= rem_nxt;
    end_r <= end_nxt;
    t_r   <= t_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    bit_nxt   = bit_r;
    cyc_nxt   = cyc_r;
    rem_nxt   = rem_r;
    end_nxt   = end_r;
    t_nxt     = t_r;
    unique case (state_r)
      LS_IDLE: begin
        if (start) begin
          k_nxt     = '0;
          cyc_nxt   = '0;
          t_nxt     = now_time;
          state_nxt = LS_SUM;
        end
      end
      LS_SUM: begin
        cyc_nxt = add_sum;
        k_nxt   = k_r + 3'd1;
        if (k_r + 3'd1 == n_eff) begin
          rem_nxt   = '0;
          bit_nxt   = '0;
          state_nxt = LS_DIV;
        end
      end
      LS_DIV: begin
        if (!trial[CYC_W]) rem_nxt = trial[CYC_W-1:0];
        else rem_nxt = {rem_r[CYC_W-2:0], t_r[TIME_W-1]};
        t_nxt   = {t_r[TIME_W-2:0], 1'b0};
        bit_nxt = bit_r + 6'd1;
        if (bit_r == 6'(TIME_W - 1)) begin
          k_nxt     = '0;
          end_nxt   = '0;
          state_nxt = LS_FIND;
        end
      end
      LS_FIND: begin
        end_nxt = add_sum;
        if (rem_r < add_sum || k_r + 3'd1 == n_eff) begin
          state_nxt = LS_DONE;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      LS_DONE: state_nxt = LS_IDLE;
      default: state_nxt = LS_IDLE;
    endcase
  end

  assign ctl.start = start;
  assign ctl.busy  = (state_r != LS_IDLE);
  assign ctl.done  = (state_r == LS_DONE);
  assign slot      = k_r[1:0];
  assign left      = end_r - rem_r;
endmodule
`default_nettype wire
